// ===== design/utt_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package utt_pkg;

  // Depth of the command queue between the classifier and the byte serializer.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Widths fixed by the data format.
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 2;

  // Surrogate ranges and encoding thresholds.
  localparam logic [UNIT_W-1:0] SUR_HIGH_FIRST = 16'hD800;
  localparam logic [UNIT_W-1:0] SUR_HIGH_LAST  = 16'hDBFF;
  localparam logic [UNIT_W-1:0] SUR_LOW_FIRST  = 16'hDC00;
  localparam logic [UNIT_W-1:0] SUR_LOW_LAST   = 16'hDFFF;
  localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [CP_W-1:0]   SUPPLEMENTARY_BASE = 21'h010000;

  // What the serializer has to do with one command.
  typedef enum logic [2:0] {
    KIND_ERROR,
    KIND_ONE,
    KIND_TWO,
    KIND_THREE,
    KIND_FOUR
  } utt_kind_t;

  typedef struct packed {
    utt_kind_t       kind;
    logic [CP_W-1:0] cp;
  } utt_cmd_t;

endpackage
`default_nettype wire

// ===== design/utt_front.sv =====
// Front end: accepts code units, pairs surrogates and classifies code points.
`timescale 1ns / 1ps
`default_nettype none
module utt_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [utt_pkg::UNIT_W-1:0] code_unit,
  input  wire logic                     final_unit,
  input  wire logic                     q_full,
  output logic                          q_push,
  output utt_pkg::utt_cmd_t             q_data
);
  import utt_pkg::*;

  logic       high_pending;
  logic       high_pending_next;
  logic [9:0] held_high_bits;
  logic [9:0] held_high_bits_next;
  logic       accept;
  logic       is_high;
  logic       is_low;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign is_high = (code_unit >= SUR_HIGH_FIRST) && (code_unit <= SUR_HIGH_LAST);
  assign is_low  = (code_unit >= SUR_LOW_FIRST) && (code_unit <= SUR_LOW_LAST);

  always_comb begin
    high_pending_next   = high_pending;
    held_high_bits_next = held_high_bits;
    q_push              = 1'b0;
    q_data.kind         = KIND_ERROR;
    q_data.cp           = '0;
    if (accept) begin
      if (high_pending) begin
        // Whatever follows a held high surrogate clears the hold.
        high_pending_next   = 1'b0;
        held_high_bits_next = '0;
        q_push              = 1'b1;
        if (is_low) begin
          q_data.kind = KIND_FOUR;
          q_data.cp   = SUPPLEMENTARY_BASE + {1'b0, held_high_bits, code_unit[9:0]};
        end
      end else if (is_high) begin
        if (final_unit) begin
          q_push = 1'b1;
        end else begin
          high_pending_next   = 1'b1;
          held_high_bits_next = code_unit[9:0];
        end
      end else if (is_low) begin
        q_push = 1'b1;
      end else begin
        q_push    = 1'b1;
        q_data.cp = {{(CP_W - UNIT_W){1'b0}}, code_unit};
        if (code_unit < ONE_BYTE_LIMIT) begin
          q_data.kind = KIND_ONE;
        end else if (code_unit < TWO_BYTE_LIMIT) begin
          q_data.kind = KIND_TWO;
        end else begin
          q_data.kind = KIND_THREE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      held_high_bits <= '0;
    end else begin
      high_pending   <= high_pending_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/utt_cmd_queue.sv =====
// Short command queue between the front end and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module utt_cmd_queue #(
  parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  utt_pkg::utt_cmd_t      wr_data,
  output logic                   q_full,
  input  wire logic              rd_en,
  output utt_pkg::utt_cmd_t      rd_data,
  output logic                   q_empty
);
  import utt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utt_cmd_t               entries [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_wr;
  logic                   do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/utt_back.sv =====
// Back end: turns one command at a time into UTF-8 bytes, one per cycle in which pop is high.
`timescale 1ns / 1ps
`default_nettype none
module utt_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  utt_pkg::utt_cmd_t               q_data,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [utt_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last_byte,
  output logic                            bad_sequence
);
  import utt_pkg::*;

  utt_cmd_t         cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic             at_last;
  logic             load;

  always_comb begin
    unique case (cur.kind)
      KIND_TWO:   last_idx = IDX_W'(1);
      KIND_THREE: last_idx = IDX_W'(2);
      KIND_FOUR:  last_idx = IDX_W'(3);
      default:    last_idx = '0;
    endcase
  end

  assign at_last = (idx == last_idx);
  assign empty   = !cur_valid;
  assign load    = (!cur_valid || (pop && at_last)) && !q_empty;
  assign q_pop   = load;

  // Byte selection for the current position within the code point.
  always_comb begin
    bad_sequence = 1'b0;
    last_byte    = at_last;
    out_byte     = '0;
    unique case (cur.kind)
      KIND_ONE: out_byte = {1'b0, cur.cp[6:0]};
      KIND_TWO: begin
        case (idx)
          2'd0:    out_byte = {3'b110, cur.cp[10:6]};
          default: out_byte = {2'b10, cur.cp[5:0]};
        endcase
      end
      KIND_THREE: begin
        case (idx)
          2'd0:    out_byte = {4'b1110, cur.cp[15:12]};
          2'd1:    out_byte = {2'b10, cur.cp[11:6]};
          default: out_byte = {2'b10, cur.cp[5:0]};
        endcase
      end
      KIND_FOUR: begin
        case (idx)
          2'd0:    out_byte = {5'b11110, cur.cp[20:18]};
          2'd1:    out_byte = {2'b10, cur.cp[17:12]};
          2'd2:    out_byte = {2'b10, cur.cp[11:6]};
          default: out_byte = {2'b10, cur.cp[5:0]};
        endcase
      end
      default: begin
        bad_sequence = 1'b1;
        last_byte    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_valid && pop) begin
      if (at_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
// The transcoder takes one UTF-16 code unit per input transaction and returns
// the UTF-8 bytes of each completed code point, one byte per result
// transaction, lead byte first, with last_byte set on the final byte. A high
// surrogate is held and gives no result; the following low surrogate completes
// a four-byte code point. A lone low surrogate, a high surrogate followed by
// anything other than a low surrogate, or a high surrogate marked final gives
// a single result with out_byte zero and both last_byte and bad_sequence set.
// An input transaction is taken whenever the command queue has room; the byte
// serializer then delivers one byte per cycle in which the receiver pops, and a
// held high surrogate gives no byte at all. The sustained rate is therefore set
// by the serializer: one result byte per clock while pop stays high and commands
// are waiting. When the serializer is idle, the first byte of a unit passes
// through the command queue and then the serializer's current-command register
// before it reaches the result ports. Both sides stall independently through
// the queue, whose depth is set by QUEUE_DEPTH.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [utt_pkg::UNIT_W-1:0]   code_unit,
  input  wire logic                         final_unit,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [utt_pkg::BYTE_W-1:0]        out_byte,
  output logic                              last_byte,
  output logic                              bad_sequence
);
  import utt_pkg::*;

  utt_cmd_t wr_cmd;
  utt_cmd_t rd_cmd;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  // Classifier: owns the held surrogate and issues one command per result group.
  utt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_unit  (code_unit),
    .final_unit (final_unit),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (wr_cmd)
  );

  // Decouples input acceptance from byte serialization.
  utt_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_cmd),
    .q_empty (q_empty)
  );

  // Serializer: holds the command being sent and steps through its bytes.
  utt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (rd_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .bad_sequence (bad_sequence)
  );

endmodule
`default_nettype wire

// ===== sim/utf16_to_utf8_transcoder_tb.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
module utf16_to_utf8_transcoder_tb;
  import utt_pkg::*;

  // The receiver holds pop low for this many cycles once during the run.
  localparam int RX_HOLD_CYCLES = 300;
  // The run fails if this many cycles pass with no transaction on either side.
  localparam int WATCHDOG_LIMIT = 3000;
  // Extra cycles after the last expected byte, in case the block sends more.
  localparam int TAIL_CYCLES = 20;

  // One UTF-8 byte as the block should deliver it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              bad;
  } utf8_byte_t;

  // The scoreboard keeps its own copy of the surrogate state. It turns each
  // accepted code unit into the bytes that the unit completes and queues them
  // in order, and each byte the block delivers is compared with the oldest
  // byte in that queue.
  class utf8_scoreboard;
    utf8_byte_t       expected_bytes[$];
    logic [9:0]       held_payload;
    logic             high_held;
    int               errors;

    function new();
      held_payload = '0;
      high_held    = 1'b0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function void queue_byte(input logic [BYTE_W-1:0] data, input logic last,
                             input logic bad);
      utf8_byte_t b;
      b.data = data;
      b.last = last;
      b.bad  = bad;
      expected_bytes.push_back(b);
    endfunction

    // Expands one code point, or an error, into its bytes, lead byte first.
    function void queue_code_point(input utt_kind_t kind, input logic [CP_W-1:0] cp);
      case (kind)
        KIND_ERROR: begin
          queue_byte(8'h00, 1'b1, 1'b1);
        end
        KIND_ONE: begin
          queue_byte(cp[7:0], 1'b1, 1'b0);
        end
        KIND_TWO: begin
          queue_byte({3'b110, cp[10:6]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
        end
        KIND_THREE: begin
          queue_byte({4'b1110, cp[15:12]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
        end
        KIND_FOUR: begin
          queue_byte({5'b11110, cp[20:18]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[17:12]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[11:6]}, 1'b0, 1'b0);
          queue_byte({2'b10, cp[5:0]}, 1'b1, 1'b0);
        end
        default: begin
        end
      endcase
    endfunction

    // Called for every accepted input transaction.
    function void note_unit(input logic [UNIT_W-1:0] unit, input logic fin);
      logic            is_high;
      logic            is_low;
      logic [9:0]      payload;
      logic [CP_W-1:0] cp;
      utt_kind_t       kind;
      is_high = (unit >= SUR_HIGH_FIRST) && (unit <= SUR_HIGH_LAST);
      is_low  = (unit >= SUR_LOW_FIRST) && (unit <= SUR_LOW_LAST);
      cp      = {{(CP_W-UNIT_W){1'b0}}, unit};
      if (high_held) begin
        // Whatever follows a held high surrogate clears it; only a low one
        // makes a pair, anything else is dropped with one error byte.
        payload      = held_payload;
        high_held    = 1'b0;
        held_payload = '0;
        if (is_low) begin
          cp   = SUPPLEMENTARY_BASE + {payload, 10'b0} + unit[9:0];
          kind = KIND_FOUR;
        end else begin
          kind = KIND_ERROR;
        end
      end else if (is_high) begin
        if (!fin) begin
          held_payload = unit[9:0];
          high_held    = 1'b1;
          return;
        end
        kind = KIND_ERROR;
      end else if (is_low) begin
        kind = KIND_ERROR;
      end else if (unit < ONE_BYTE_LIMIT) begin
        kind = KIND_ONE;
      end else if (unit < TWO_BYTE_LIMIT) begin
        kind = KIND_TWO;
      end else begin
        kind = KIND_THREE;
      end
      queue_code_point(kind, cp);
    endfunction

    // Called for every accepted result transaction.
    task check_byte(input logic [BYTE_W-1:0] data, input logic last, input logic bad);
      utf8_byte_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last=%0b bad=%0b",
                                  data, last, bad));
      end else begin
        want = expected_bytes.pop_front();
        if (data !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
        if (last !== want.last)
          report_mismatch($sformatf("last_byte %0b, expected %0b", last, want.last));
        if (bad !== want.bad)
          report_mismatch($sformatf("bad_sequence %0b, expected %0b", bad, want.bad));
      end
    endtask
  endclass

  // Every input of the block has a known value from time zero on.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [UNIT_W-1:0] code_unit = '0;
  logic              final_unit = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;
  logic              bad_sequence;

  // Percent of cycles in which each side sits idle; the main sequence changes
  // them from phase to phase.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  // Set by the main sequence to have the receiver stall for a long stretch.
  logic rx_hold_req = 1'b0;

  int   quiet_cycles = 0;
  logic took;

  utf8_scoreboard sb = new();

  utf16_to_utf8_transcoder dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .code_unit    (code_unit),
    .final_unit   (final_unit),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .bad_sequence (bad_sequence)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor. All inputs change by nonblocking assignment at the rising edge,
  // so the values read here are the ones the block saw at this edge. An input
  // transaction updates the prediction; a result transaction is checked. The
  // same process runs the watchdog, which ends the run when neither side has
  // moved a transaction for too long.
  always @(posedge clk) begin
    if (!rst) begin
      took = 1'b0;
      if (push && !full) begin
        sb.note_unit(code_unit, final_unit);
        took = 1'b1;
      end
      if (pop && !empty) begin
        sb.check_byte(out_byte, last_byte, bad_sequence);
        took = 1'b1;
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: watchdog expired with %0d bytes outstanding",
                 $time, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver. Each cycle pop is raised or left low at random. On request it
  // holds pop low for a long stretch, counted here, so that the block fills
  // up and has to stall the sender.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one code unit and returns at the edge where the block takes it.
  // Push stays high on return, so back-to-back units go out with no gap
  // unless the idle roll says otherwise.
  task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    code_unit  <= unit;
    final_unit <= fin;
    do @(posedge clk); while (full);
  endtask

  // Stops offering units until every expected byte has been delivered. The
  // count is read at the falling edge, after the monitor has run.
  task automatic pause_until_drained();
    push <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  // Random text: mostly well-formed content of every encoded length, with a
  // share of broken surrogate sequences and fully random units mixed in.
  task automatic send_random_text(input int count);
    int                sent;
    int                pick;
    logic              fin;
    logic [UNIT_W-1:0] unit;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      fin  = ($urandom_range(0, 9) == 0);
      if (pick < 38) begin
        // Well-formed pair with random payloads.
        send_unit(SUR_HIGH_FIRST | 16'($urandom_range(0, 1023)), 1'b0);
        send_unit(SUR_LOW_FIRST | 16'($urandom_range(0, 1023)), fin);
        sent += 2;
      end else if (pick < 53) begin
        send_unit(16'($urandom_range(0, 16'h007F)), fin);
        sent++;
      end else if (pick < 64) begin
        send_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin);
        sent++;
      end else if (pick < 77) begin
        if ($urandom_range(0, 1) == 0)
          unit = 16'($urandom_range(16'h0800, 16'hD7FF));
        else
          unit = 16'($urandom_range(16'hE000, 16'hFFFF));
        send_unit(unit, fin);
        sent++;
      end else if (pick < 83) begin
        // Low surrogate with nothing held.
        send_unit(SUR_LOW_FIRST | 16'($urandom_range(0, 1023)), fin);
        sent++;
      end else if (pick < 90) begin
        // High surrogate followed by an arbitrary unit, usually not a low one.
        send_unit(SUR_HIGH_FIRST | 16'($urandom_range(0, 1023)), 1'b0);
        send_unit(16'($urandom), fin);
        sent += 2;
      end else if (pick < 94) begin
        // High surrogate that ends the string.
        send_unit(SUR_HIGH_FIRST | 16'($urandom_range(0, 1023)), 1'b1);
        sent++;
      end else begin
        send_unit(16'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    // Reset is held once, at the start of the run.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // First phase: sender idles a little, receiver idles a lot.
    tx_idle_pct = 12;
    rx_idle_pct = 81;

    // Directed units: the edges of every encoded length and the surrogate
    // corner cases.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    // Smallest and largest pairs, then a pair whose low half ends the string.
    send_unit(SUR_HIGH_FIRST, 1'b0);
    send_unit(SUR_LOW_FIRST, 1'b0);
    send_unit(SUR_HIGH_LAST, 1'b0);
    send_unit(SUR_LOW_LAST, 1'b0);
    send_unit(16'hD834, 1'b0);
    send_unit(16'hDD1E, 1'b1);
    // Low surrogates with nothing held.
    send_unit(SUR_LOW_FIRST, 1'b0);
    send_unit(SUR_LOW_LAST, 1'b1);
    // A high surrogate followed by plain text, then by another high
    // surrogate, which is dropped along with the first.
    send_unit(SUR_HIGH_FIRST, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(SUR_HIGH_LAST, 1'b0);
    send_unit(SUR_HIGH_FIRST, 1'b0);
    // A high surrogate that ends the string with nothing held.
    send_unit(16'hD900, 1'b1);
    // The final mark on plain text has no effect.
    send_unit(16'h0041, 1'b1);
    // A high surrogate followed by a final unit that is not a low one.
    send_unit(SUR_HIGH_FIRST, 1'b0);
    send_unit(16'h0020, 1'b1);

    // Back pressure: the receiver stalls for a long stretch while the sender
    // keeps offering units, so the block fills and raises full. Afterwards
    // the sender waits for every outstanding byte.
    rx_hold_req = 1'b1;
    send_random_text(24);
    pause_until_drained();

    send_random_text(100);
    pause_until_drained();

    // Second phase: the sender is the slow side.
    tx_idle_pct = 81;
    rx_idle_pct = 12;
    send_random_text(100);
    pause_until_drained();

    // Third phase: both sides run flat out.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_text(100);
    pause_until_drained();

    // Give the block time to show any byte it should not send.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/utt_pkg.sv
design/utt_front.sv
design/utt_cmd_queue.sv
design/utt_back.sv
design/utf16_to_utf8_transcoder.sv
sim/utf16_to_utf8_transcoder_tb.sv
